### rtl/wsu_pkg.sv
// wsu_pkg: shared types and constants for the frame unmasker
// no dependencies; used by every module in rtl/

package wsu_pkg;

  // frame kind codes as seen on out_frame_kind
  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;

  // first-byte opcodes
  localparam logic [7:0] OPCODE_CLOSE  = 8'd136;
  localparam logic [7:0] OPCODE_BINARY = 8'd130;

  // length code handling
  localparam logic [7:0] LEN_CODE_MASK      = 8'd127;
  localparam logic [6:0] LEN_CODE_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_CODE_16        = 7'd126;

  // mask key start positions and key length
  localparam logic [3:0] MASK_AT_SHORT = 4'd2;
  localparam logic [3:0] MASK_AT_16    = 4'd4;
  localparam logic [3:0] MASK_AT_64    = 4'd10;
  localparam logic [3:0] MASK_LEN      = 4'd4;

  // header positions
  localparam logic [3:0] POS_OPCODE = 4'd0;
  localparam logic [3:0] POS_LENGTH = 4'd1;

  // one transfer worth of result plus an emit flag
  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [1:0] frame_kind;
    logic       end_of_frame;
  } wsu_result_t;

  // held input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       frame_end;
  } wsu_item_t;

endpackage

### rtl/wsu_in_reg.sv
// wsu_in_reg: input register stage of the frame unmasker
// depends on wsu_pkg

module wsu_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_frame_end,
  output logic              in_stall,
  input  logic              adv,
  output wsu_pkg::wsu_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       load;

  // stage can take a new byte when empty or moving on this cycle
  assign in_stall  = valid_r && !adv;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
      end_r  <= in_frame_end;
    end
  end

  assign item.valid     = valid_r;
  assign item.rx_byte   = byte_r;
  assign item.frame_end = end_r;

endmodule

### rtl/wsu_deframe.sv
// wsu_deframe: header tracking, mask key capture and payload xor
// depends on wsu_pkg

module wsu_deframe (
  input  logic                clk,
  input  logic                rst_n,
  input  wsu_pkg::wsu_item_t  item,
  input  logic                adv,
  output wsu_pkg::wsu_result_t res
);

  logic [3:0] pos_r, pos_nxt;
  logic [3:0] mstart_r, mstart_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] key_r [4];
  logic       key_we;
  logic [1:0] key_idx;
  logic [3:0] data_start;
  logic [3:0] key_off;
  logic [6:0] len_code;
  logic       pay_valid;
  logic [7:0] pay_byte;

  assign data_start = mstart_r + wsu_pkg::MASK_LEN;
  assign key_off    = pos_r - mstart_r;
  assign key_idx    = key_off[1:0];
  assign len_code   = 7'(item.rx_byte & wsu_pkg::LEN_CODE_MASK);

  always_comb begin
    pos_nxt    = pos_r;
    mstart_nxt = mstart_r;
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    key_we     = 1'b0;
    pay_valid  = 1'b0;
    pay_byte   = 8'd0;
    if (pos_r == wsu_pkg::POS_OPCODE) begin
      if (item.rx_byte == wsu_pkg::OPCODE_CLOSE) begin
        kind_nxt = wsu_pkg::KIND_CLOSE;
      end else if (item.rx_byte == wsu_pkg::OPCODE_BINARY) begin
        kind_nxt = wsu_pkg::KIND_BINARY;
      end else begin
        kind_nxt = wsu_pkg::KIND_TEXT;
      end
      pos_nxt = wsu_pkg::POS_LENGTH;
    end else if (pos_r == wsu_pkg::POS_LENGTH) begin
      if (len_code <= wsu_pkg::LEN_CODE_SHORT_MAX) begin
        mstart_nxt = wsu_pkg::MASK_AT_SHORT;
      end else if (len_code == wsu_pkg::LEN_CODE_16) begin
        mstart_nxt = wsu_pkg::MASK_AT_16;
      end else begin
        mstart_nxt = wsu_pkg::MASK_AT_64;
      end
      pos_nxt = pos_r + 4'd1;
    end else if (pos_r < data_start) begin
      // extended length bytes are skipped, mask bytes captured
      key_we  = (pos_r >= mstart_r);
      pos_nxt = pos_r + 4'd1;
    end else begin
      if (kind_r == wsu_pkg::KIND_TEXT) begin
        pay_valid = 1'b1;
        pay_byte  = item.rx_byte ^ key_r[phase_r];
      end
      phase_nxt = phase_r + 2'd1;
    end
    // end mark restarts header tracking, key and kind persist
    if (item.frame_end) begin
      pos_nxt    = wsu_pkg::POS_OPCODE;
      mstart_nxt = wsu_pkg::MASK_AT_SHORT;
      phase_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= wsu_pkg::POS_OPCODE;
      mstart_r <= wsu_pkg::MASK_AT_SHORT;
      phase_r  <= 2'd0;
      kind_r   <= wsu_pkg::KIND_TEXT;
      key_r    <= '{default: 8'd0};
    end else if (adv) begin
      pos_r    <= pos_nxt;
      mstart_r <= mstart_nxt;
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      if (key_we) begin
        key_r[key_idx] <= item.rx_byte;
      end
    end
  end

  assign res.emit         = item.valid && (pay_valid || item.frame_end);
  assign res.payload_byte = pay_byte;
  assign res.byte_valid   = pay_valid;
  assign res.frame_kind   = kind_nxt;
  assign res.end_of_frame = item.frame_end;

endmodule

### rtl/wsu_out_reg.sv
// wsu_out_reg: result register driving the out_ channel
// depends on wsu_pkg

module wsu_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsu_pkg::wsu_result_t res,
  input  logic                 load,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_payload_byte,
  output logic                 out_byte_valid,
  output logic [1:0]           out_frame_kind,
  output logic                 out_end_of_frame
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic [1:0] kind_r;
  logic       eof_r;

  // slot is free when empty or its transfer completes this cycle
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= res.payload_byte;
      bvalid_r <= res.byte_valid;
      kind_r   <= res.frame_kind;
      eof_r    <= res.end_of_frame;
    end
  end

  assign out_valid        = valid_r;
  assign out_payload_byte = byte_r;
  assign out_byte_valid   = bvalid_r;
  assign out_frame_kind   = kind_r;
  assign out_end_of_frame = eof_r;

endmodule

### rtl/websocket_frame_unmasker.sv
// websocket_frame_unmasker: top level, deframes and unmasks received client frames
// depends on wsu_pkg, wsu_in_reg, wsu_deframe, wsu_out_reg
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid in_stall in_rx_byte in_frame_end    | into block
//   out     | out_valid out_stall out_payload_byte         | out of block
//           | out_byte_valid out_frame_kind out_end_of_frame|
//
// one byte per cycle sustained while out_stall is low; each result is registered
// first in the input register and then in the result register before it is offered
// bytes that give no result (header bytes, non-text payload) retire without
// touching the result register
// reset is synchronous on rst_n low: empties both registers and restarts at
// the opcode byte with a text kind and an all-zero mask key
// a stalled result holds the input register only when the held byte has a
// result to send, which then stalls the input

module websocket_frame_unmasker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_byte_valid,
  output logic [1:0] out_frame_kind,
  output logic       out_end_of_frame
);

  wsu_pkg::wsu_item_t   item;
  wsu_pkg::wsu_result_t res;
  logic                 out_free;
  logic                 adv;

  // held byte retires when it has nothing to send or the result slot frees up
  assign adv = item.valid && (!res.emit || out_free);

  wsu_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_rx_byte   (in_rx_byte),
    .in_frame_end (in_frame_end),
    .in_stall     (in_stall),
    .adv          (adv),
    .item         (item)
  );

  // header state, mask key and xor
  wsu_deframe u_deframe (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .adv   (adv),
    .res   (res)
  );

  // result is loaded only for bytes that produce a transfer
  wsu_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .load             (adv && res.emit),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_kind   (out_frame_kind),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

### rtl/wsu_checker.sv
// wsu_checker: port-level checks for the frame unmasker, bound to the top level
// depends on wsu_pkg and websocket_frame_unmasker

module wsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_byte_valid,
  input logic [1:0] out_frame_kind,
  input logic       out_end_of_frame
);

  // stalled result keeps out_valid, payload byte and end flag until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_end_of_frame))
    else $error("result changed while stalled");

  // a result without a payload byte only marks a frame end
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_frame && out_payload_byte == 8'd0)
    else $error("empty result without frame end");

  // payload bytes only come from text frames
  a_payload_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_frame_kind == wsu_pkg::KIND_TEXT)
    else $error("payload byte from non-text frame");

  // frame kind is always one of the three known codes
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_kind == wsu_pkg::KIND_TEXT
      || out_frame_kind == wsu_pkg::KIND_CLOSE
      || out_frame_kind == wsu_pkg::KIND_BINARY)
    else $error("bad frame kind");

endmodule

bind websocket_frame_unmasker wsu_checker u_wsu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_payload_byte (out_payload_byte),
  .out_byte_valid   (out_byte_valid),
  .out_frame_kind   (out_frame_kind),
  .out_end_of_frame (out_end_of_frame)
);
